// File: rtl/dtq_pkg.sv
// Shared types and constants of the delta timer queue.
package dtq_pkg;

    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = 5;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_DEL  = 2'd1,
        OP_TICK = 2'd2,
        OP_NOP  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_ACK       = 2'd0,
        KIND_EXPIRED   = 2'd1,
        KIND_IDLE_TICK = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_ADD    = 2'd1,
        ST_NOT_ARMED  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        RD_CUR  = 2'd0,
        RD_D    = 2'd1,
        RD_NX   = 2'd2,
        RD_HEAD = 2'd3
    } rd_sel_t;

    typedef struct packed {
        logic    latch_in;
        logic    add_init;
        logic    add_step;
        logic    add_link;
        logic    del_set_s;
        logic    del_read;
        logic    del_fix;
        logic    del_walk;
        logic    del_done;
        logic    tick_init;
        logic    tick_dec;
        logic    tick_take;
        logic    emit;
        kind_t   emit_kind;
        status_t emit_status;
        logic    emit_last;
        rd_sel_t rd_sel;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic bad_add;
        logic bad_del;
        logic head_null;
        logic add_end;
        logic add_hit;
        logic dwalk_end;
        logic dwalk_hit;
        logic del_head;
        logic expire;
        logic have_pend;
        logic out_free;
    } stat_t;

endpackage

// File: rtl/dtq_ctrl.sv
// Sequencing state machine of the delta timer queue.
module dtq_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  dtq_pkg::stat_t stat,
    output dtq_pkg::cmd_t  cmd
);
    import dtq_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE       = 11'b00000000001,
        S_DECODE     = 11'b00000000010,
        S_ADD_WALK   = 11'b00000000100,
        S_ADD_LINK   = 11'b00000001000,
        S_DEL_A      = 11'b00000010000,
        S_DEL_B      = 11'b00000100000,
        S_DEL_WALK   = 11'b00001000000,
        S_DEL_DONE   = 11'b00010000000,
        S_TICK_DEC   = 11'b00100000000,
        S_TICK_CHECK = 11'b01000000000,
        S_ACK        = 11'b10000000000
    } state_t;

    state_t  state_reg, state_next;
    status_t st_reg, st_next;
    logic    tick_mode_reg, tick_mode_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next     = state_reg;
        st_next        = st_reg;
        tick_mode_next = tick_mode_reg;
        cmd            = '0;
        cmd.rd_sel     = RD_HEAD;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE: begin
                tick_mode_next = 1'b0;
                case (stat.op)
                    OP_ADD: begin
                        if (stat.bad_add) begin
                            st_next    = ST_BAD_ADD;
                            state_next = S_ACK;
                        end else begin
                            cmd.add_init = 1'b1;
                            state_next   = S_ADD_WALK;
                        end
                    end
                    OP_DEL: begin
                        if (stat.bad_del) begin
                            st_next    = ST_NOT_ARMED;
                            state_next = S_ACK;
                        end else begin
                            cmd.del_set_s = 1'b1;
                            state_next    = S_DEL_A;
                        end
                    end
                    OP_TICK: begin
                        tick_mode_next = 1'b1;
                        cmd.tick_init  = 1'b1;
                        state_next     = S_TICK_DEC;
                    end
                    default: begin
                        st_next    = ST_OK;
                        state_next = S_ACK;
                    end
                endcase
            end
            S_ADD_WALK: begin
                cmd.rd_sel = RD_CUR;
                if (stat.add_end) begin
                    state_next = S_ADD_LINK;
                end else begin
                    cmd.add_step = 1'b1;
                    if (stat.add_hit) begin
                        state_next = S_ADD_LINK;
                    end
                end
            end
            S_ADD_LINK: begin
                cmd.add_link = 1'b1;
                st_next      = ST_OK;
                state_next   = S_ACK;
            end
            S_DEL_A: begin
                cmd.rd_sel   = RD_D;
                cmd.del_read = 1'b1;
                state_next   = S_DEL_B;
            end
            S_DEL_B: begin
                cmd.rd_sel  = RD_NX;
                cmd.del_fix = 1'b1;
                state_next  = stat.del_head ? S_DEL_DONE : S_DEL_WALK;
            end
            S_DEL_WALK: begin
                cmd.rd_sel   = RD_CUR;
                cmd.del_walk = 1'b1;
                if (stat.dwalk_end || stat.dwalk_hit) begin
                    state_next = S_DEL_DONE;
                end
            end
            S_DEL_DONE: begin
                cmd.del_done = 1'b1;
                if (tick_mode_reg) begin
                    state_next = S_TICK_CHECK;
                end else begin
                    st_next    = ST_OK;
                    state_next = S_ACK;
                end
            end
            S_TICK_DEC: begin
                cmd.tick_dec = 1'b1;
                state_next   = S_TICK_CHECK;
            end
            S_TICK_CHECK: begin
                if (stat.expire) begin
                    if (!stat.have_pend) begin
                        cmd.tick_take = 1'b1;
                        state_next    = S_DEL_A;
                    end else if (stat.out_free) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = KIND_EXPIRED;
                        cmd.tick_take = 1'b1;
                        state_next    = S_DEL_A;
                    end
                end else if (stat.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = stat.have_pend ? KIND_EXPIRED : KIND_IDLE_TICK;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_ACK: begin
                if (stat.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_kind   = KIND_ACK;
                    cmd.emit_status = st_reg;
                    cmd.emit_last   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            st_reg        <= ST_OK;
            tick_mode_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            st_reg        <= st_next;
            tick_mode_reg <= tick_mode_next;
        end
    end

endmodule

// File: rtl/dtq_datapath.sv
// Slot tables, list pointers and result register of the delta timer queue.
module dtq_datapath #(
    parameter int TIMER_SLOTS = 16,
    parameter int TICK_BITS   = 32
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [47:0]    s_tdata,
    input  logic [1:0]     s_tuser,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [23:0]    m_tdata,
    output logic [1:0]     m_tuser,
    output logic           m_tlast,
    input  dtq_pkg::cmd_t  cmd,
    output dtq_pkg::stat_t stat
);
    import dtq_pkg::*;

    localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int LW = SW + 1;
    localparam logic [LW-1:0] NULL_LINK = LW'(TIMER_SLOTS);

    logic [TIMER_SLOTS-1:0] armed_reg;
    logic [TICK_BITS-1:0]   delta_reg [TIMER_SLOTS];
    logic [11:0]            owner_reg [TIMER_SLOTS];
    logic [LW-1:0]          next_reg  [TIMER_SLOTS];
    logic [LW-1:0]          head_reg;

    op_t                  op_reg;
    logic [3:0]           slot_reg;
    logic [11:0]          who_reg;
    logic [TICK_BITS-1:0] rem_reg;
    logic [LW-1:0]        cur_reg, prev_reg, steps_reg, d_reg, nx_reg;
    logic [TICK_BITS-1:0] dd_reg;
    logic [CNT_W-1:0]     n_reg;
    logic                 pend_reg;
    logic [SW-1:0]        pend_slot_reg;
    logic [11:0]          pend_owner_reg;

    logic                 out_valid_reg;
    kind_t                out_kind_reg;
    status_t              out_status_reg;
    logic [3:0]           out_slot_reg;
    logic [11:0]          out_wake_reg;
    logic                 out_last_reg;

    logic [LW-1:0]        rd_ptr;
    logic [SW-1:0]        rd_idx, s_idx, cur_idx, prev_idx, d_idx, nx_idx, head_idx;
    logic [TICK_BITS-1:0] rd_delta, t_in;
    logic [LW-1:0]        rd_next, rd_next_norm;
    logic [11:0]          rd_owner;
    logic                 slot_ok, cur_null, steps_full, out_free;

    always_comb begin
        case (cmd.rd_sel)
            RD_CUR:  rd_ptr = cur_reg;
            RD_D:    rd_ptr = d_reg;
            RD_NX:   rd_ptr = nx_reg;
            default: rd_ptr = head_reg;
        endcase
    end

    assign rd_idx   = rd_ptr[SW-1:0];
    assign s_idx    = SW'(slot_reg);
    assign cur_idx  = cur_reg[SW-1:0];
    assign prev_idx = prev_reg[SW-1:0];
    assign d_idx    = d_reg[SW-1:0];
    assign nx_idx   = nx_reg[SW-1:0];
    assign head_idx = head_reg[SW-1:0];

    assign rd_delta     = delta_reg[rd_idx];
    assign rd_next      = next_reg[rd_idx];
    assign rd_owner     = owner_reg[rd_idx];
    assign rd_next_norm = (rd_next >= NULL_LINK) ? NULL_LINK : rd_next;
    assign t_in         = TICK_BITS'(s_tdata[47:16]);

    assign slot_ok    = (32'(slot_reg) < TIMER_SLOTS);
    assign cur_null   = (cur_reg >= NULL_LINK);
    assign steps_full = (steps_reg == NULL_LINK);
    assign out_free   = !out_valid_reg || m_tready;

    always_comb begin
        stat.op        = op_reg;
        stat.bad_add   = (rem_reg == '0) || !slot_ok || armed_reg[s_idx];
        stat.bad_del   = !slot_ok || !armed_reg[s_idx];
        stat.head_null = (head_reg >= NULL_LINK);
        stat.add_end   = cur_null || steps_full;
        stat.add_hit   = (rem_reg < rd_delta);
        stat.dwalk_end = cur_null || steps_full;
        stat.dwalk_hit = (rd_next == d_reg);
        stat.del_head  = (head_reg == d_reg);
        stat.expire    = (head_reg < NULL_LINK) && (rd_delta == '0) &&
                         (n_reg < CNT_W'(MAX_RESULTS));
        stat.have_pend = pend_reg;
        stat.out_free  = out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg <= '0;
            head_reg  <= NULL_LINK;
        end else begin
            if (cmd.add_link) begin
                armed_reg[s_idx] <= 1'b1;
                if (prev_reg >= NULL_LINK) begin
                    head_reg <= LW'(s_idx);
                end
            end
            if (cmd.del_fix && stat.del_head) begin
                head_reg <= nx_reg;
            end
            if (cmd.del_done) begin
                armed_reg[d_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            op_reg   <= op_t'(s_tuser);
            slot_reg <= s_tdata[3:0];
            who_reg  <= s_tdata[15:4];
            rem_reg  <= t_in;
        end
        if (cmd.add_init) begin
            cur_reg   <= head_reg;
            prev_reg  <= NULL_LINK;
            steps_reg <= '0;
        end
        if (cmd.add_step) begin
            if (stat.add_hit) begin
                delta_reg[cur_idx] <= rd_delta - rem_reg;
            end else begin
                rem_reg   <= rem_reg - rd_delta;
                prev_reg  <= cur_reg;
                cur_reg   <= rd_next;
                steps_reg <= steps_reg + 1'b1;
            end
        end
        if (cmd.add_link) begin
            delta_reg[s_idx] <= rem_reg;
            owner_reg[s_idx] <= who_reg;
            next_reg[s_idx]  <= cur_null ? NULL_LINK : cur_reg;
            if (prev_reg < NULL_LINK) begin
                next_reg[prev_idx] <= LW'(s_idx);
            end
        end
        if (cmd.del_set_s) begin
            d_reg <= LW'(s_idx);
        end
        if (cmd.del_read) begin
            nx_reg <= rd_next_norm;
            dd_reg <= rd_delta;
        end
        if (cmd.del_fix) begin
            if (nx_reg < NULL_LINK) begin
                delta_reg[nx_idx] <= rd_delta + dd_reg;
            end
            cur_reg   <= head_reg;
            steps_reg <= '0;
        end
        if (cmd.del_walk && !stat.dwalk_end) begin
            if (stat.dwalk_hit) begin
                next_reg[cur_idx] <= nx_reg;
            end else begin
                cur_reg   <= rd_next;
                steps_reg <= steps_reg + 1'b1;
            end
        end
        if (cmd.tick_init) begin
            n_reg    <= '0;
            pend_reg <= 1'b0;
        end
        if (cmd.tick_dec && !stat.head_null && rd_delta != '0) begin
            delta_reg[head_idx] <= rd_delta - 1'b1;
        end
        if (cmd.tick_take) begin
            pend_reg       <= 1'b1;
            pend_slot_reg  <= head_idx;
            pend_owner_reg <= rd_owner;
            d_reg          <= head_reg;
            n_reg          <= n_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_kind_reg   <= cmd.emit_kind;
            out_status_reg <= cmd.emit_status;
            out_last_reg   <= cmd.emit_last;
            case (cmd.emit_kind)
                KIND_ACK: begin
                    out_slot_reg <= slot_reg;
                    out_wake_reg <= '0;
                end
                KIND_EXPIRED: begin
                    out_slot_reg <= 4'(pend_slot_reg);
                    out_wake_reg <= pend_owner_reg;
                end
                default: begin
                    out_slot_reg <= '0;
                    out_wake_reg <= '0;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_wake_reg, out_slot_reg, out_status_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: rtl/delta_timer_queue_core.sv
// Top level of the delta timer queue: controller joined to the datapath.
// Timer slots form one list ordered by expiry, each entry holding its delay
// relative to the entry before it. One command is handled at a time and the
// next is taken once the last result of the current one is in the output
// register. An add steps once per list entry it passes over (up to
// TIMER_SLOTS), a delete walks from the head while searching its predecessor,
// and a tick decrements the head's delay and then removes each expired timer
// through the delete steps; the walk over the linked slots does one table read
// per cycle. Rejected commands and no-ops go straight to the acknowledge.
module delta_timer_queue_core #(
    parameter int TIMER_SLOTS = 16,
    parameter int TICK_BITS   = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // slot[3:0], owner_id[15:4], ticks[47:16]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // status[1:0], expired_slot[5:2], wake_id[17:6]
    output logic [1:0]  m_tuser,   // kind[1:0]
    output logic        m_tlast
);
    import dtq_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    dtq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dtq_datapath #(
        .TIMER_SLOTS (TIMER_SLOTS),
        .TICK_BITS   (TICK_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

// File: rtl/dtq_checker.sv
// Port-level checks of the delta timer queue and their binding.
module dtq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    import dtq_pkg::*;

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_ack_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_ACK) |-> (m_tlast && m_tdata[23:6] == '0))
        else $error("command acknowledge not last or wake_id nonzero");

    a_idle_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_IDLE_TICK) |-> (m_tlast && m_tdata == '0))
        else $error("empty tick result malformed");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule

bind delta_timer_queue_core dtq_checker u_dtq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
